>>> hw/rtl/cs_pkg.sv
// shared types and character constants for the comment stripper
package cs_pkg;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'h22;

  // depth of the queue between the front and the back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    ModeNormal    = 3'd0,
    ModeQuote     = 3'd1,
    ModeLine      = 3'd2,
    ModeBlock     = 3'd3,
    ModeBlockStar = 3'd4
  } cs_mode_e;

  // one classified input beat with at least one kept byte
  typedef struct packed {
    logic       two;   // a held slash goes out ahead of data
    logic [7:0] data;
    logic       eot;
  } cs_rec_t;

endpackage

>>> hw/rtl/cs_front.sv
// front end: scan state machine that classifies each input byte
module cs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_text_i,
  output logic           rec_valid_o,
  output cs_pkg::cs_rec_t rec_o
);
  import cs_pkg::*;

  cs_mode_e mode_q, mode_d;
  logic     slash_q, slash_d;
  logic     has_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      slash_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    slash_d  = slash_q;
    has_byte = 1'b0;
    rec_o.two  = 1'b0;
    rec_o.data = in_byte_i;
    rec_o.eot  = end_of_text_i;
    case (mode_q)
      ModeQuote: begin
        has_byte = 1'b1;
        if (in_byte_i == ChQuote) mode_d = ModeNormal;
      end
      ModeLine: begin
        if (in_byte_i == ChNl) begin
          has_byte = 1'b1;
          mode_d   = ModeNormal;
        end
      end
      ModeBlock: begin
        if (in_byte_i == ChStar) mode_d = ModeBlockStar;
      end
      ModeBlockStar: begin
        if (in_byte_i == ChSlash) mode_d = ModeNormal;
        else if (in_byte_i != ChStar) mode_d = ModeBlock;
      end
      default: begin
        mode_d = ModeNormal;
        if (slash_q && (in_byte_i == ChSlash)) begin
          slash_d = 1'b0;
          mode_d  = ModeLine;
        end else if (slash_q && (in_byte_i == ChStar)) begin
          slash_d = 1'b0;
          mode_d  = ModeBlock;
        end else begin
          // held slash, if any, goes out first
          rec_o.two = slash_q;
          slash_d   = 1'b0;
          if (in_byte_i == ChSlash) begin
            if (end_of_text_i) has_byte = 1'b1;
            else slash_d = 1'b1;
          end else begin
            if (in_byte_i == ChQuote) mode_d = ModeQuote;
            has_byte = 1'b1;
          end
        end
      end
    endcase
    // end of text returns the scanner to its reset state
    if (end_of_text_i) begin
      mode_d  = ModeNormal;
      slash_d = 1'b0;
    end
  end

  assign rec_valid_o = accept_i && has_byte;

endmodule

>>> hw/rtl/cs_queue.sv
// small queue of classified records between front and back
module cs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cs_pkg::cs_rec_t wdata_i,
  input  logic            pop_i,
  output cs_pkg::cs_rec_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import cs_pkg::*;

  cs_rec_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wptr_q, rptr_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> hw/rtl/cs_back.sv
// back end: splits records into result beats and holds the output register
module cs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rec_avail_i,
  input  cs_pkg::cs_rec_t rec_i,
  output logic            rec_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o,
  output logic            text_done_o
);
  import cs_pkg::*;

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q, done_q;
  logic       phase_q;   // slash of a two-beat record already sent
  logic       load, first_slash;

  assign load        = rec_avail_i && (!out_valid_q || pop_i);
  assign first_slash = rec_i.two && !phase_q;
  assign rec_pop_o   = load && !first_slash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= first_slash;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= first_slash ? ChSlash : rec_i.data;
      last_q <= !first_slash;
      done_q <= rec_i.eot;
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign text_done_o   = done_q;

endmodule

>>> hw/rtl/comment_stripper_top.sv
// top level of the comment stripper
// Strips C-style comments from a byte stream. Each input beat is one raw text
// byte plus an end_of_text flag; output beats carry the kept bytes in order,
// zero to two per input byte. Line comments are dropped up to their newline
// (the newline is kept), block comments are dropped whole, text in double
// quotes passes untouched, and a lone slash is held one byte before it goes
// out. After the end_of_text byte the scanner is back in its reset state.
// Rate: one input byte is accepted every cycle while the internal queue has
// room; the output side delivers one beat per cycle while the receiver pops,
// so a byte that yields two results (held slash plus byte) takes two beats.
// On an idle output the first result of a byte passes the internal queue and
// the output register, then shows and can be taken at the next rising edge.
module comment_stripper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       text_done_o
);
  import cs_pkg::*;

  logic    accept;
  logic    rec_valid, q_full, q_empty, q_pop;
  cs_rec_t rec_in, rec_out;

  // an input beat is taken whenever the middle queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: scan state machine, emits a record only for bytes that are kept
  cs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .rec_valid_o   (rec_valid),
    .rec_o         (rec_in)
  );

  // decoupling queue between front and back
  cs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .wdata_i (rec_in),
    .pop_i   (q_pop),
    .rdata_o (rec_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: turns each record into one or two output beats
  cs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_avail_i   (!q_empty),
    .rec_i         (rec_out),
    .rec_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

endmodule

>>> tb/sv/tb.sv
// testbench for comment_stripper_top: directed and random text against a byte-level predictor
`timescale 1ns / 1ps

module tb;
  import cs_pkg::*;

  // one kept byte as the result side should show it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } kept_t;

  // clock, reset and block inputs, all known from time zero
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       pop           = 1'b0;

  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       text_done_o;

  // predictor state: scanner mode and a slash held back in normal text
  cs_mode_e   scan_mode  = ModeNormal;
  logic       slash_held = 1'b0;

  // kept bytes still to come out of the block, oldest first
  kept_t      kept_q[$];
  kept_t      want;

  // random text under construction
  logic [7:0] text_q[$];

  // when set, neither side idles
  bit         quiet     = 1'b1;
  int         pop_wait  = 0;

  int         err_cnt   = 0;
  int         bytes_in  = 0;
  int         kept_seen = 0;
  int         texts     = 0;
  int         drains    = 0;

  comment_stripper_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

  always #4 clk_i = ~clk_i;

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // work out the kept bytes for one accepted input beat
  task automatic predict_kept(input logic [7:0] b, input logic eot);
    logic [7:0] outs[2];
    int         n;
    kept_t      item;
    n = 0;
    case (scan_mode)
      ModeQuote: begin
        outs[n] = b;
        n++;
        if (b == ChQuote) scan_mode = ModeNormal;
      end
      ModeLine: begin
        // the newline that ends a line comment is kept
        if (b == ChNl) begin
          outs[n] = b;
          n++;
          scan_mode = ModeNormal;
        end
      end
      ModeBlock: begin
        if (b == ChStar) scan_mode = ModeBlockStar;
      end
      ModeBlockStar: begin
        if (b == ChSlash) scan_mode = ModeNormal;
        else if (b != ChStar) scan_mode = ModeBlock;
      end
      default: begin
        scan_mode = ModeNormal;
        if (slash_held && b == ChSlash) begin
          slash_held = 1'b0;
          scan_mode  = ModeLine;
        end else if (slash_held && b == ChStar) begin
          slash_held = 1'b0;
          scan_mode  = ModeBlock;
        end else begin
          // a held slash goes out ahead of whatever follows
          if (slash_held) begin
            outs[n]    = ChSlash;
            n++;
            slash_held = 1'b0;
          end
          // a slash is held unless it is the last byte of the text
          if (b == ChSlash && !eot) begin
            slash_held = 1'b1;
          end else begin
            if (b == ChQuote) scan_mode = ModeQuote;
            outs[n] = b;
            n++;
          end
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      item = '{data: outs[k], last: (k == n - 1), done: eot};
      kept_q.insert(kept_q.size(), item);
    end
    // the block starts over after the final byte of a text
    if (eot) begin
      scan_mode  = ModeNormal;
      slash_held = 1'b0;
      texts++;
    end
  endtask

  // drive one input beat from the falling edge, hold until taken, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int g;
    @(negedge clk_i);
    push          <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (full);
    predict_kept(b, eot);
    bytes_in++;
    g = idle_len();
    if (g > 0) begin
      @(negedge clk_i);
      push          <= 1'b0;
      in_byte_i     <= 8'($urandom_range(0, 255));
      end_of_text_i <= 1'($urandom_range(0, 1));
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_at_end && (i == s.len() - 1));
    end
  endtask

  // hold the sender off until every kept byte has come out
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (kept_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    drains++;
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  // append one byte at the tail of the text under construction
  task automatic add_text_byte(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  // append one random token to the text under construction
  task automatic add_token();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(0, 6);
    case (kind)
      0, 1, 2: begin
        // ordinary letters and spaces
        for (int i = 0; i <= n; i++) begin
          add_text_byte(($urandom_range(0, 5) == 0) ? 8'h20
                                                    : 8'(8'h61 + $urandom_range(0, 25)));
        end
      end
      3: begin
        // line comment, newline usually present
        add_text_byte(ChSlash);
        add_text_byte(ChSlash);
        for (int i = 0; i < n; i++) add_text_byte(any_but(ChNl, ChNl));
        if ($urandom_range(0, 9) != 0) add_text_byte(ChNl);
      end
      4: begin
        // block comment with stars and slashes inside, usually closed
        add_text_byte(ChSlash);
        add_text_byte(ChStar);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0:       add_text_byte(ChStar);
            1:       add_text_byte(ChSlash);
            default: add_text_byte(8'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 6) != 0) begin
          add_text_byte(ChStar);
          add_text_byte(ChSlash);
        end
      end
      5: begin
        // quoted text with comment openers inside
        add_text_byte(ChQuote);
        for (int i = 0; i < n; i++) begin
          add_text_byte(($urandom_range(0, 2) == 0) ? ChSlash : any_but(ChQuote, ChQuote));
        end
        if ($urandom_range(0, 7) != 0) add_text_byte(ChQuote);
      end
      6: begin
        // lone slash before an ordinary byte
        add_text_byte(ChSlash);
        add_text_byte(any_but(ChSlash, ChStar));
      end
      7: begin
        // opener star that must not close, then a real close
        add_text_byte(ChSlash);
        add_text_byte(ChStar);
        add_text_byte(ChSlash);
        add_text_byte(ChStar);
        add_text_byte(ChStar);
        add_text_byte(ChSlash);
      end
      default: begin
        // raw noise over the whole byte range
        for (int i = 0; i <= n % 4; i++) add_text_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // plain bytes at both ends of the range
  task automatic test_plain_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // held slash, line comment, block comment closing rules, quotes
  task automatic test_comment_forms();
    send_text("/x", 1'b0);
    send_text("//q\n", 1'b0);
    send_text("/*/**/", 1'b0);
    send_text("\"//\"", 1'b0);
  endtask

  // how each kind of final byte ends a text
  task automatic test_text_ends();
    send_text("/", 1'b1);
    send_text("//", 1'b1);
    send_text("/*z", 1'b1);
    send_text("/k", 1'b1);
  endtask

  // random texts: a stretch with no idling, a full drain, then idling on both sides
  task automatic test_random_text();
    while (bytes_in < 835) begin
      text_q.delete();
      repeat ($urandom_range(1, 8)) add_token();
      while (text_q.size() != 0) begin
        send_byte(text_q[0], text_q.size() == 1);
        void'(text_q.pop_front());
      end
      if (quiet && bytes_in > 180) begin
        wait_drained();
        quiet = 1'b0;
      end else if (!quiet) begin
        if ($urandom_range(0, 11) == 0) wait_drained();
        // now and then a text runs with both sides at full rate
        quiet = ($urandom_range(0, 9) == 0);
      end
    end
    quiet = 1'b0;
  endtask

  // result side: pop changes at the falling edge, stalls of random length
  always @(negedge clk_i) begin
    if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_wait = idle_len();
    end
  end

  // each result beat is checked against the oldest expected kept byte
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (kept_q.size() == 0) begin
        $error("unexpected beat: out_byte %02h", out_byte_o);
        err_cnt++;
      end else begin
        want = kept_q.pop_front();
        kept_seen++;
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte_o);
          err_cnt++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_o);
          err_cnt++;
        end
        if (text_done_o !== want.done) begin
          $error("text_done: expected %0b, got %0b", want.done, text_done_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    quiet = 1'b0;

    test_plain_extremes();
    test_comment_forms();
    test_text_ends();
    quiet = 1'b1;
    test_random_text();

    // let everything drain, then keep watching for stray beats
    @(negedge clk_i);
    push <= 1'b0;
    while (kept_q.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d bytes in %0d texts sent, %0d kept bytes checked", bytes_in, texts,
             kept_seen);
    $display("tb: %0d full drains, %0d mismatches", drains, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cs_pkg.sv
hw/rtl/cs_front.sv
hw/rtl/cs_queue.sv
hw/rtl/cs_back.sv
hw/rtl/comment_stripper_top.sv
tb/sv/tb.sv
